// File: hw/rtl/sgdma_pkg.sv
`timescale 1ns / 1ps

package sgdma_pkg;

   // request command codes
   localparam logic [1:0] REQ_CMD_WRITE = 2'd0;
   localparam logic [1:0] REQ_CMD_READ  = 2'd1;
   localparam logic [1:0] REQ_CMD_TICK  = 2'd2;

   // fixed register words
   localparam logic [6:0] WORD_STATUS    = 7'd0;
   localparam logic [6:0] WORD_COMMAND   = 7'd1;
   localparam logic [6:0] WORD_CAP_HI    = 7'd2;
   localparam logic [6:0] WORD_CAP_LO    = 7'd3;
   localparam logic [6:0] WORD_BADDR_HI  = 7'd4;
   localparam logic [6:0] WORD_BADDR_LO  = 7'd5;
   localparam logic [6:0] WORD_BCNT_HI   = 7'd6;
   localparam logic [6:0] WORD_BCNT_LO   = 7'd7;
   localparam logic [6:0] WORD_DESC_BASE = 7'd8;

   // word within a descriptor
   localparam logic [1:0] DESC_ADDR_HI = 2'd0;
   localparam logic [1:0] DESC_ADDR_LO = 2'd1;
   localparam logic [1:0] DESC_CNT_HI  = 2'd2;
   localparam logic [1:0] DESC_CNT_LO  = 2'd3;

   localparam logic [31:0] CMD_DISK_TO_MEM = 32'd1;
   localparam logic [31:0] STATUS_DONE     = 32'd1;

   // disk block is 512 bytes
   localparam int BLOCK_SHIFT = 9;

   typedef enum logic [1:0] {
      OP_NONE,
      OP_READ,
      OP_WRITE,
      OP_TICK
   } op_kind_type;

   typedef struct packed {
      op_kind_type kind;
      logic        is_desc;
      logic [1:0]  desc_sub;
      logic [6:0]  word_index;
      logic [31:0] write_data;
   } op_type;

endpackage

// File: hw/rtl/sgdma_front.sv
`timescale 1ns / 1ps

module sgdma_front #(
   parameter int NUM_DESCRIPTORS = 16
) (
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [1:0]          req_cmd,
   input  logic [6:0]          req_word_index,
   input  logic [31:0]         req_write_data,
   output logic                push_valid,
   output sgdma_pkg::op_type   push_op,
   input  logic                push_ready
);

   localparam int NUM_WORDS = 8 + 4 * NUM_DESCRIPTORS;

   logic in_window;

   assign in_window  = 32'(req_word_index) < 32'(NUM_WORDS);
   assign req_stall  = !push_ready;
   assign push_valid = req_valid;

   always_comb begin
      push_op.word_index = req_word_index;
      push_op.write_data = req_write_data;
      push_op.is_desc    = in_window && (req_word_index >= sgdma_pkg::WORD_DESC_BASE);
      push_op.desc_sub   = 2'(req_word_index - sgdma_pkg::WORD_DESC_BASE);
      case (req_cmd)
         sgdma_pkg::REQ_CMD_WRITE: begin
            push_op.kind = in_window ? sgdma_pkg::OP_WRITE : sgdma_pkg::OP_NONE;
         end
         sgdma_pkg::REQ_CMD_READ: begin
            push_op.kind = in_window ? sgdma_pkg::OP_READ : sgdma_pkg::OP_NONE;
         end
         sgdma_pkg::REQ_CMD_TICK: begin
            push_op.kind = sgdma_pkg::OP_TICK;
         end
         default: begin
            push_op.kind = sgdma_pkg::OP_NONE;
         end
      endcase
   end

endmodule

// File: hw/rtl/sgdma_queue.sv
`timescale 1ns / 1ps

module sgdma_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   input  sgdma_pkg::op_type   push_op,
   output logic                push_ready,
   output logic                head_valid,
   output sgdma_pkg::op_type   head_op,
   input  logic                pop
);

   sgdma_pkg::op_type entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;

   assign push_ready = count_ff != 2'd2;
   assign head_valid = count_ff != 2'd0;
   assign head_op    = entry_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_op;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// File: hw/rtl/sgdma_back.sv
`timescale 1ns / 1ps

module sgdma_back #(
   parameter int NUM_DESCRIPTORS = 16,
   parameter int CHUNK_BYTES     = 512
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_write_enable,
   input  logic [63:0]         csr_write_data,
   input  logic                q_valid,
   input  sgdma_pkg::op_type   q_op,
   output logic                q_pop,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [31:0]         rsp_read_data,
   output logic                rsp_chunk_valid,
   output logic                rsp_chunk_to_memory,
   output logic [63:0]         rsp_chunk_disk_offset,
   output logic [31:0]         rsp_chunk_mem_addr,
   output logic [9:0]          rsp_chunk_length,
   output logic                rsp_busy_res,
   output logic                rsp_irq,
   output logic                rsp_done_res
);

   localparam int DIDX_W = (NUM_DESCRIPTORS > 1) ? $clog2(NUM_DESCRIPTORS) : 1;
   localparam int LEN_W  = $clog2(CHUNK_BYTES + 1);
   localparam logic [DIDX_W-1:0] LAST_DESC = DIDX_W'(NUM_DESCRIPTORS - 1);

   typedef enum logic {
      S_ISSUE,
      S_EXEC
   } state_type;

   state_type state_ff, state_in;
   sgdma_pkg::op_type cur_op_ff, cur_op_in;

   // register words
   logic [31:0] status_ff, status_in;
   logic [31:0] command_ff, command_in;
   logic [31:0] baddr_hi_ff, baddr_hi_in;
   logic [31:0] baddr_lo_ff, baddr_lo_in;
   logic [31:0] bcnt_hi_ff, bcnt_hi_in;
   logic [31:0] bcnt_lo_ff, bcnt_lo_in;
   logic [63:0] capacity_ff, capacity_in;

   // transfer walk
   logic              active_ff, active_in;
   logic              irq_ff, irq_in;
   logic [DIDX_W-1:0] desc_num_ff, desc_num_in;
   logic [31:0]       total_ff, total_in;
   logic [31:0]       bld_ff, bld_in;
   logic [63:0]       disk_ptr_ff, disk_ptr_in;
   logic [31:0]       mem_ptr_ff, mem_ptr_in;

   // result register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_read_data_ff, rsp_read_data_in;
   logic        rsp_chunk_valid_ff, rsp_chunk_valid_in;
   logic        rsp_to_mem_ff, rsp_to_mem_in;
   logic [63:0] rsp_disk_ff, rsp_disk_in;
   logic [31:0] rsp_mem_ff, rsp_mem_in;
   logic [9:0]  rsp_len_ff, rsp_len_in;
   logic        rsp_busy_ff, rsp_busy_in;
   logic        rsp_irq_ff, rsp_irq_in;
   logic        rsp_done_ff, rsp_done_in;

   // descriptor storage, entries read as zero until written
   logic [31:0] addr_hi_mem [NUM_DESCRIPTORS];
   logic [31:0] addr_lo_mem [NUM_DESCRIPTORS];
   logic [31:0] cnt_hi_mem  [NUM_DESCRIPTORS];
   logic [31:0] cnt_lo_mem  [NUM_DESCRIPTORS];
   logic [NUM_DESCRIPTORS-1:0] addr_hi_vld_ff, addr_hi_vld_in;
   logic [NUM_DESCRIPTORS-1:0] addr_lo_vld_ff, addr_lo_vld_in;
   logic [NUM_DESCRIPTORS-1:0] cnt_hi_vld_ff, cnt_hi_vld_in;
   logic [NUM_DESCRIPTORS-1:0] cnt_lo_vld_ff, cnt_lo_vld_in;
   logic [31:0] addr_hi_rd_ff, addr_lo_rd_ff, cnt_hi_rd_ff, cnt0_rd_ff, cnt1_rd_ff;

   logic              out_free;
   logic              issue;
   logic              exec_fire;
   logic              mem_we;
   logic              chunk_fire;
   logic [LEN_W-1:0]  chunk_len;
   logic [DIDX_W-1:0] q_widx, cur_widx, rd_idx, d_next, addr_lo_idx, cnt0_idx;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign q_widx   = DIDX_W'((q_op.word_index - sgdma_pkg::WORD_DESC_BASE) >> 2);
   assign cur_widx = DIDX_W'((cur_op_ff.word_index - sgdma_pkg::WORD_DESC_BASE) >> 2);
   assign rd_idx   = (q_op.kind == sgdma_pkg::OP_READ && q_op.is_desc) ? q_widx : '0;
   assign d_next   = (desc_num_ff == LAST_DESC) ? desc_num_ff : desc_num_ff + DIDX_W'(1);
   assign addr_lo_idx = (q_op.kind == sgdma_pkg::OP_TICK) ? d_next : rd_idx;
   assign cnt0_idx    = (q_op.kind == sgdma_pkg::OP_TICK) ? desc_num_ff : rd_idx;

   always_comb begin
      logic [31:0] total_after;
      logic [31:0] bld_after;
      logic [31:0] status_eff;
      logic        do_close;
      logic        do_complete;

      state_in    = state_ff;
      cur_op_in   = cur_op_ff;
      status_in   = status_ff;
      command_in  = command_ff;
      baddr_hi_in = baddr_hi_ff;
      baddr_lo_in = baddr_lo_ff;
      bcnt_hi_in  = bcnt_hi_ff;
      bcnt_lo_in  = bcnt_lo_ff;
      capacity_in = csr_write_enable ? csr_write_data : capacity_ff;
      active_in   = active_ff;
      irq_in      = irq_ff;
      desc_num_in = desc_num_ff;
      total_in    = total_ff;
      bld_in      = bld_ff;
      disk_ptr_in = disk_ptr_ff;
      mem_ptr_in  = mem_ptr_ff;

      rsp_valid_in       = rsp_valid_ff && rsp_stall;
      rsp_read_data_in   = rsp_read_data_ff;
      rsp_chunk_valid_in = rsp_chunk_valid_ff;
      rsp_to_mem_in      = rsp_to_mem_ff;
      rsp_disk_in        = rsp_disk_ff;
      rsp_mem_in         = rsp_mem_ff;
      rsp_len_in         = rsp_len_ff;
      rsp_busy_in        = rsp_busy_ff;
      rsp_irq_in         = rsp_irq_ff;
      rsp_done_in        = rsp_done_ff;

      q_pop       = 1'b0;
      issue       = 1'b0;
      exec_fire   = 1'b0;
      mem_we      = 1'b0;
      chunk_fire  = 1'b0;
      chunk_len   = '0;
      total_after = total_ff;
      bld_after   = bld_ff;
      status_eff  = status_ff;
      do_close    = 1'b0;
      do_complete = 1'b0;

      case (state_ff)
         S_ISSUE: begin
            if (q_valid) begin
               q_pop     = 1'b1;
               issue     = 1'b1;
               cur_op_in = q_op;
               state_in  = S_EXEC;
            end
         end
         S_EXEC: begin
            if (out_free) begin
               exec_fire          = 1'b1;
               state_in           = S_ISSUE;
               rsp_valid_in       = 1'b1;
               rsp_read_data_in   = '0;
               rsp_chunk_valid_in = 1'b0;
               rsp_to_mem_in      = 1'b0;
               rsp_disk_in        = '0;
               rsp_mem_in         = '0;
               rsp_len_in         = '0;
               rsp_done_in        = 1'b0;
               case (cur_op_ff.kind)
                  sgdma_pkg::OP_READ: begin
                     if (cur_op_ff.is_desc) begin
                        case (cur_op_ff.desc_sub)
                           sgdma_pkg::DESC_ADDR_HI: rsp_read_data_in = addr_hi_rd_ff;
                           sgdma_pkg::DESC_ADDR_LO: rsp_read_data_in = addr_lo_rd_ff;
                           sgdma_pkg::DESC_CNT_HI:  rsp_read_data_in = cnt_hi_rd_ff;
                           default:                 rsp_read_data_in = cnt0_rd_ff;
                        endcase
                     end else begin
                        case (cur_op_ff.word_index)
                           sgdma_pkg::WORD_STATUS:   rsp_read_data_in = status_ff;
                           sgdma_pkg::WORD_COMMAND:  rsp_read_data_in = command_ff;
                           sgdma_pkg::WORD_CAP_HI:   rsp_read_data_in = capacity_ff[63:32];
                           sgdma_pkg::WORD_CAP_LO:   rsp_read_data_in = capacity_ff[31:0];
                           sgdma_pkg::WORD_BADDR_HI: rsp_read_data_in = baddr_hi_ff;
                           sgdma_pkg::WORD_BADDR_LO: rsp_read_data_in = baddr_lo_ff;
                           sgdma_pkg::WORD_BCNT_HI:  rsp_read_data_in = bcnt_hi_ff;
                           sgdma_pkg::WORD_BCNT_LO:  rsp_read_data_in = bcnt_lo_ff;
                           default:                  rsp_read_data_in = '0;
                        endcase
                     end
                     if (!status_ff[0]) begin
                        irq_in = 1'b0;
                     end
                  end
                  sgdma_pkg::OP_WRITE: begin
                     if (cur_op_ff.is_desc) begin
                        mem_we = 1'b1;
                     end else begin
                        case (cur_op_ff.word_index)
                           sgdma_pkg::WORD_STATUS: begin
                              status_in  = cur_op_ff.write_data;
                              status_eff = cur_op_ff.write_data;
                           end
                           sgdma_pkg::WORD_COMMAND:  command_in  = cur_op_ff.write_data;
                           sgdma_pkg::WORD_BADDR_HI: baddr_hi_in = cur_op_ff.write_data;
                           sgdma_pkg::WORD_BADDR_LO: baddr_lo_in = cur_op_ff.write_data;
                           sgdma_pkg::WORD_BCNT_HI:  bcnt_hi_in  = cur_op_ff.write_data;
                           sgdma_pkg::WORD_BCNT_LO:  bcnt_lo_in  = cur_op_ff.write_data;
                           default: ; // capacity words are read-only
                        endcase
                     end
                     if (!status_eff[0]) begin
                        irq_in = 1'b0;
                     end
                     // command going zero to nonzero starts a transfer when none is active
                     if (!cur_op_ff.is_desc && cur_op_ff.word_index == sgdma_pkg::WORD_COMMAND
                         && command_ff == '0 && cur_op_ff.write_data != '0 && !active_ff) begin
                        active_in   = 1'b1;
                        disk_ptr_in = {baddr_hi_ff, baddr_lo_ff} << sgdma_pkg::BLOCK_SHIFT;
                        total_in    = bcnt_lo_ff << sgdma_pkg::BLOCK_SHIFT;
                        desc_num_in = '0;
                        mem_ptr_in  = addr_lo_rd_ff;
                        bld_in      = cnt0_rd_ff;
                     end
                  end
                  sgdma_pkg::OP_TICK: begin
                     if (active_ff) begin
                        if (total_ff == '0) begin
                           do_complete = 1'b1;
                        end else if (bld_ff != '0) begin
                           chunk_fire = 1'b1;
                           chunk_len  = (bld_ff > 32'(CHUNK_BYTES)) ? LEN_W'(CHUNK_BYTES)
                                                                     : LEN_W'(bld_ff);
                           rsp_chunk_valid_in = 1'b1;
                           rsp_to_mem_in      = command_ff == sgdma_pkg::CMD_DISK_TO_MEM;
                           rsp_disk_in        = disk_ptr_ff;
                           rsp_mem_in         = mem_ptr_ff;
                           rsp_len_in         = 10'(chunk_len);
                           disk_ptr_in        = disk_ptr_ff + 64'(chunk_len);
                           mem_ptr_in         = mem_ptr_ff + 32'(chunk_len);
                           bld_after          = bld_ff - 32'(chunk_len);
                           bld_in             = bld_after;
                           do_close           = bld_after == '0;
                        end else begin
                           do_close = 1'b1;
                        end
                        if (do_close) begin
                           // total drops by the live count word, floor at zero
                           total_after = (total_ff > cnt0_rd_ff) ? total_ff - cnt0_rd_ff : '0;
                           total_in    = total_after;
                           if (total_after == '0 || desc_num_ff == LAST_DESC) begin
                              do_complete = 1'b1;
                           end else begin
                              desc_num_in = d_next;
                              mem_ptr_in  = addr_lo_rd_ff;
                              bld_in      = cnt1_rd_ff;
                           end
                        end
                        if (do_complete) begin
                           command_in  = '0;
                           status_in   = sgdma_pkg::STATUS_DONE;
                           irq_in      = 1'b1;
                           active_in   = 1'b0;
                           rsp_done_in = 1'b1;
                        end
                     end
                  end
                  default: ;
               endcase
               rsp_busy_in = active_in;
               rsp_irq_in  = irq_in;
            end
         end
         default: begin
            state_in = S_ISSUE;
         end
      endcase

      addr_hi_vld_in = addr_hi_vld_ff;
      addr_lo_vld_in = addr_lo_vld_ff;
      cnt_hi_vld_in  = cnt_hi_vld_ff;
      cnt_lo_vld_in  = cnt_lo_vld_ff;
      if (mem_we) begin
         case (cur_op_ff.desc_sub)
            sgdma_pkg::DESC_ADDR_HI: addr_hi_vld_in[cur_widx] = 1'b1;
            sgdma_pkg::DESC_ADDR_LO: addr_lo_vld_in[cur_widx] = 1'b1;
            sgdma_pkg::DESC_CNT_HI:  cnt_hi_vld_in[cur_widx]  = 1'b1;
            default:                 cnt_lo_vld_in[cur_widx]  = 1'b1;
         endcase
      end
   end

   // descriptor memories: one write port, registered reads
   always_ff @(posedge clock) begin
      if (mem_we) begin
         case (cur_op_ff.desc_sub)
            sgdma_pkg::DESC_ADDR_HI: addr_hi_mem[cur_widx] <= cur_op_ff.write_data;
            sgdma_pkg::DESC_ADDR_LO: addr_lo_mem[cur_widx] <= cur_op_ff.write_data;
            sgdma_pkg::DESC_CNT_HI:  cnt_hi_mem[cur_widx]  <= cur_op_ff.write_data;
            default:                 cnt_lo_mem[cur_widx]  <= cur_op_ff.write_data;
         endcase
      end
      if (issue) begin
         addr_hi_rd_ff <= addr_hi_vld_ff[rd_idx] ? addr_hi_mem[rd_idx] : '0;
         cnt_hi_rd_ff  <= cnt_hi_vld_ff[rd_idx] ? cnt_hi_mem[rd_idx] : '0;
         addr_lo_rd_ff <= addr_lo_vld_ff[addr_lo_idx] ? addr_lo_mem[addr_lo_idx] : '0;
         cnt0_rd_ff    <= cnt_lo_vld_ff[cnt0_idx] ? cnt_lo_mem[cnt0_idx] : '0;
         cnt1_rd_ff    <= cnt_lo_vld_ff[d_next] ? cnt_lo_mem[d_next] : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_ISSUE;
         status_ff      <= '0;
         command_ff     <= '0;
         baddr_hi_ff    <= '0;
         baddr_lo_ff    <= '0;
         bcnt_hi_ff     <= '0;
         bcnt_lo_ff     <= '0;
         capacity_ff    <= '0;
         active_ff      <= 1'b0;
         irq_ff         <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         addr_hi_vld_ff <= '0;
         addr_lo_vld_ff <= '0;
         cnt_hi_vld_ff  <= '0;
         cnt_lo_vld_ff  <= '0;
      end else begin
         state_ff       <= state_in;
         status_ff      <= status_in;
         command_ff     <= command_in;
         baddr_hi_ff    <= baddr_hi_in;
         baddr_lo_ff    <= baddr_lo_in;
         bcnt_hi_ff     <= bcnt_hi_in;
         bcnt_lo_ff     <= bcnt_lo_in;
         capacity_ff    <= capacity_in;
         active_ff      <= active_in;
         irq_ff         <= irq_in;
         rsp_valid_ff   <= rsp_valid_in;
         addr_hi_vld_ff <= addr_hi_vld_in;
         addr_lo_vld_ff <= addr_lo_vld_in;
         cnt_hi_vld_ff  <= cnt_hi_vld_in;
         cnt_lo_vld_ff  <= cnt_lo_vld_in;
      end
      cur_op_ff          <= cur_op_in;
      desc_num_ff        <= desc_num_in;
      total_ff           <= total_in;
      bld_ff             <= bld_in;
      disk_ptr_ff        <= disk_ptr_in;
      mem_ptr_ff         <= mem_ptr_in;
      rsp_read_data_ff   <= rsp_read_data_in;
      rsp_chunk_valid_ff <= rsp_chunk_valid_in;
      rsp_to_mem_ff      <= rsp_to_mem_in;
      rsp_disk_ff        <= rsp_disk_in;
      rsp_mem_ff         <= rsp_mem_in;
      rsp_len_ff         <= rsp_len_in;
      rsp_busy_ff        <= rsp_busy_in;
      rsp_irq_ff         <= rsp_irq_in;
      rsp_done_ff        <= rsp_done_in;
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_read_data         = rsp_read_data_ff;
   assign rsp_chunk_valid       = rsp_chunk_valid_ff;
   assign rsp_chunk_to_memory   = rsp_to_mem_ff;
   assign rsp_chunk_disk_offset = rsp_disk_ff;
   assign rsp_chunk_mem_addr    = rsp_mem_ff;
   assign rsp_chunk_length      = rsp_len_ff;
   assign rsp_busy_res          = rsp_busy_ff;
   assign rsp_irq               = rsp_irq_ff;
   assign rsp_done_res          = rsp_done_ff;

   a_done_idle_irq: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_done_ff |-> !rsp_busy_ff && rsp_irq_ff)
      else $error("completion without irq or with busy still set");

   a_chunk_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_chunk_valid_ff |-> rsp_busy_ff || rsp_done_ff)
      else $error("chunk issued outside a transfer");

   a_chunk_len: assert property (@(posedge clock) disable iff (reset)
      exec_fire && chunk_fire |-> chunk_len != '0 && 32'(chunk_len) <= 32'(CHUNK_BYTES))
      else $error("chunk length out of range");

   a_desc_range: assert property (@(posedge clock) disable iff (reset)
      active_ff |-> desc_num_ff <= LAST_DESC)
      else $error("descriptor number past last descriptor");

   a_exec_hold: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_EXEC && !out_free |=> state_ff == S_EXEC && $stable(cur_op_ff))
      else $error("transaction dropped while result register stalled");

endmodule

// File: hw/rtl/block_disk_sg_dma_controller.sv
`timescale 1ns / 1ps
// An accepted request waits in the 2-entry queue, which decouples the front end from
// the back end; the back end takes it in its issue state (registered descriptor memory
// read) and registers its result in the execute state before it takes the next one.
// Reset: synchronous, active high; clears control, register words and descriptor
// valid bits at once (all words read as zero), no clearing pass.
module block_disk_sg_dma_controller #(
   parameter int NUM_DESCRIPTORS = 16,
   parameter int CHUNK_BYTES     = 512
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_write_enable,
   input  logic [63:0]  csr_write_data,
   input  logic         req_valid,
   output logic         req_stall,
   input  logic [1:0]   req_cmd,
   input  logic [6:0]   req_word_index,
   input  logic [31:0]  req_write_data,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output logic [31:0]  rsp_read_data,
   output logic         rsp_chunk_valid,
   output logic         rsp_chunk_to_memory,
   output logic [63:0]  rsp_chunk_disk_offset,
   output logic [31:0]  rsp_chunk_mem_addr,
   output logic [9:0]   rsp_chunk_length,
   output logic         rsp_busy_res,
   output logic         rsp_irq,
   output logic         rsp_done_res
);

   logic              push_valid;
   logic              push_ready;
   sgdma_pkg::op_type push_op;
   logic              head_valid;
   sgdma_pkg::op_type head_op;
   logic              pop;

   sgdma_front #(
      .NUM_DESCRIPTORS (NUM_DESCRIPTORS)
   ) u_front (
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_cmd        (req_cmd),
      .req_word_index (req_word_index),
      .req_write_data (req_write_data),
      .push_valid     (push_valid),
      .push_op        (push_op),
      .push_ready     (push_ready)
   );

   sgdma_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_op    (push_op),
      .push_ready (push_ready),
      .head_valid (head_valid),
      .head_op    (head_op),
      .pop        (pop)
   );

   sgdma_back #(
      .NUM_DESCRIPTORS (NUM_DESCRIPTORS),
      .CHUNK_BYTES     (CHUNK_BYTES)
   ) u_back (
      .clock                 (clock),
      .reset                 (reset),
      .csr_write_enable      (csr_write_enable),
      .csr_write_data        (csr_write_data),
      .q_valid               (head_valid),
      .q_op                  (head_op),
      .q_pop                 (pop),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_read_data         (rsp_read_data),
      .rsp_chunk_valid       (rsp_chunk_valid),
      .rsp_chunk_to_memory   (rsp_chunk_to_memory),
      .rsp_chunk_disk_offset (rsp_chunk_disk_offset),
      .rsp_chunk_mem_addr    (rsp_chunk_mem_addr),
      .rsp_chunk_length      (rsp_chunk_length),
      .rsp_busy_res          (rsp_busy_res),
      .rsp_irq               (rsp_irq),
      .rsp_done_res          (rsp_done_res)
   );

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;

   localparam int NUM_DESC     = 16;
   localparam int CHUNK        = 512;
   localparam int NUM_WORDS    = 8 + 4 * NUM_DESC;
   localparam int QUIET_LIMIT  = 3000;
   localparam int LONG_HOLD_AT = 150;
   // no such command in the package: the block must ignore it
   localparam logic [1:0] REQ_CMD_UNUSED = 2'd3;
   // any nonzero command other than disk-to-memory moves data to disk
   localparam logic [31:0] CMD_MEM_TO_DISK = 32'd2;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [6:0]  word_index;
      logic [31:0] write_data;
   } bus_access_type;

   typedef struct packed {
      logic [31:0] read_data;
      logic        chunk_valid;
      logic        to_mem;
      logic [63:0] disk_off;
      logic [31:0] mem_addr;
      logic [9:0]  len;
      logic        busy;
      logic        irq;
      logic        done;
   } dma_reply_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_write_enable = 1'b0;
   logic [63:0] csr_write_data = '0;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_cmd = sgdma_pkg::REQ_CMD_READ;
   logic [6:0]  req_word_index = sgdma_pkg::WORD_STATUS;
   logic [31:0] req_write_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_read_data;
   logic        rsp_chunk_valid;
   logic        rsp_chunk_to_memory;
   logic [63:0] rsp_chunk_disk_offset;
   logic [31:0] rsp_chunk_mem_addr;
   logic [9:0]  rsp_chunk_length;
   logic        rsp_busy_res;
   logic        rsp_irq;
   logic        rsp_done_res;

   block_disk_sg_dma_controller #(
      .NUM_DESCRIPTORS(NUM_DESC),
      .CHUNK_BYTES(CHUNK)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .csr_write_enable(csr_write_enable),
      .csr_write_data(csr_write_data),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_cmd(req_cmd),
      .req_word_index(req_word_index),
      .req_write_data(req_write_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_read_data(rsp_read_data),
      .rsp_chunk_valid(rsp_chunk_valid),
      .rsp_chunk_to_memory(rsp_chunk_to_memory),
      .rsp_chunk_disk_offset(rsp_chunk_disk_offset),
      .rsp_chunk_mem_addr(rsp_chunk_mem_addr),
      .rsp_chunk_length(rsp_chunk_length),
      .rsp_busy_res(rsp_busy_res),
      .rsp_irq(rsp_irq),
      .rsp_done_res(rsp_done_res)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // controller shadow state
   logic [31:0] ctl_regs [NUM_WORDS];
   logic [63:0] capacity = '0;
   logic        xfer_active = 1'b0;
   int          desc_idx = 0;
   logic [31:0] total_left = '0;
   logic [31:0] desc_left = '0;
   logic [63:0] disk_ptr = '0;
   logic [31:0] mem_ptr = '0;
   logic        irq_line = 1'b0;

   bus_access_type access_q [$];
   dma_reply_type  awaited_replies [$];

   // generator-side view of block count and descriptor counts, to size tick runs
   logic [31:0] plan_counts [NUM_DESC];
   logic [31:0] plan_bcnt = '0;
   int          queued_total = 0;

   logic           idle_on = 1'b0;
   int             fault_count = 0;
   int             reported = 0;
   int             replies_seen = 0;
   int             gap_left = 0;
   int             stall_left = 0;
   logic           long_hold_done = 1'b0;
   int             quiet_cycles = 0;
   bus_access_type next_access;
   dma_reply_type  predicted;
   dma_reply_type  observed;
   dma_reply_type  expected_reply;

   initial begin
      for (int i = 0; i < NUM_WORDS; i++) ctl_regs[i] = '0;
      for (int i = 0; i < NUM_DESC; i++) plan_counts[i] = '0;
   end

   function automatic logic [6:0] desc_word(input int d, input logic [1:0] sub);
      desc_word = 7'(int'(sgdma_pkg::WORD_DESC_BASE) + 4 * d + int'(sub));
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [31:0] pick_word();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return 32'h0;
      if (r == 1) return 32'hffff_ffff;
      return $urandom;
   endfunction

   // descriptor byte counts stay small so that every walk ends quickly
   function automatic logic [31:0] pick_count();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return 32'd0;
      if (r == 1) return 32'(CHUNK);
      if (r == 2) return 32'd1;
      return $urandom_range(1, 1600);
   endfunction

   function automatic string reply_str(input dma_reply_type r);
      return $sformatf("rd=%h chunk=%b to_mem=%b disk=%h mem=%h len=%0d busy=%b irq=%b done=%b",
                       r.read_data, r.chunk_valid, r.to_mem, r.disk_off, r.mem_addr, r.len,
                       r.busy, r.irq, r.done);
   endfunction

   task automatic load_desc(input int d);
      desc_idx  = d;
      mem_ptr   = ctl_regs[desc_word(d, sgdma_pkg::DESC_ADDR_LO)];
      desc_left = ctl_regs[desc_word(d, sgdma_pkg::DESC_CNT_LO)];
   endtask

   task automatic finish_xfer();
      ctl_regs[sgdma_pkg::WORD_COMMAND] = '0;
      ctl_regs[sgdma_pkg::WORD_STATUS]  = sgdma_pkg::STATUS_DONE;
      irq_line    = 1'b1;
      xfer_active = 1'b0;
   endtask

   // total shrinks by the live count word and saturates; the walk ends at zero total or the last one
   task automatic close_desc(output logic finished);
      logic [31:0] c;
      c = ctl_regs[desc_word(desc_idx, sgdma_pkg::DESC_CNT_LO)];
      total_left = (total_left > c) ? total_left - c : '0;
      finished = 1'b0;
      if (total_left == 0 || desc_idx + 1 >= NUM_DESC) begin
         finish_xfer();
         finished = 1'b1;
      end else begin
         load_desc(desc_idx + 1);
      end
   endtask

   task automatic apply_access(input logic [1:0] cmd, input logic [6:0] wi,
                               input logic [31:0] wd, output dma_reply_type r);
      logic [31:0] prev_cmd;
      logic [63:0] blk;
      logic [31:0] step;
      r = '0;
      if ((cmd == sgdma_pkg::REQ_CMD_WRITE || cmd == sgdma_pkg::REQ_CMD_READ)
          && wi < NUM_WORDS) begin
         prev_cmd = ctl_regs[sgdma_pkg::WORD_COMMAND];
         if (cmd == sgdma_pkg::REQ_CMD_READ) begin
            if (wi == sgdma_pkg::WORD_CAP_HI) r.read_data = capacity[63:32];
            else if (wi == sgdma_pkg::WORD_CAP_LO) r.read_data = capacity[31:0];
            else r.read_data = ctl_regs[wi];
         end else if (wi != sgdma_pkg::WORD_CAP_HI && wi != sgdma_pkg::WORD_CAP_LO) begin
            ctl_regs[wi] = wd;
         end
         if (ctl_regs[sgdma_pkg::WORD_STATUS][0] == 1'b0) irq_line = 1'b0;
         if (prev_cmd == 0 && ctl_regs[sgdma_pkg::WORD_COMMAND] != 0 && !xfer_active) begin
            blk         = {ctl_regs[sgdma_pkg::WORD_BADDR_HI], ctl_regs[sgdma_pkg::WORD_BADDR_LO]};
            xfer_active = 1'b1;
            disk_ptr    = blk << sgdma_pkg::BLOCK_SHIFT;
            total_left  = ctl_regs[sgdma_pkg::WORD_BCNT_LO] << sgdma_pkg::BLOCK_SHIFT;
            load_desc(0);
         end
      end else if (cmd == sgdma_pkg::REQ_CMD_TICK && xfer_active) begin
         if (total_left == 0) begin
            finish_xfer();
            r.done = 1'b1;
         end else if (desc_left > 0) begin
            step          = (desc_left > 32'(CHUNK)) ? 32'(CHUNK) : desc_left;
            r.chunk_valid = 1'b1;
            r.to_mem      = (ctl_regs[sgdma_pkg::WORD_COMMAND] == sgdma_pkg::CMD_DISK_TO_MEM);
            r.disk_off    = disk_ptr;
            r.mem_addr    = mem_ptr;
            r.len         = step[9:0];
            disk_ptr      = disk_ptr + 64'(step);
            mem_ptr       = mem_ptr + step;
            desc_left     = desc_left - step;
            if (desc_left == 0) close_desc(r.done);
         end else begin
            close_desc(r.done);
         end
      end
      r.busy = xfer_active;
      r.irq  = irq_line;
   endtask

   task automatic queue_access(input logic [1:0] cmd, input logic [6:0] wi, input logic [31:0] wd);
      bus_access_type a;
      a.cmd        = cmd;
      a.word_index = wi;
      a.write_data = wd;
      access_q.push_back(a);
      queued_total++;
      if (cmd == sgdma_pkg::REQ_CMD_WRITE) begin
         if (wi == sgdma_pkg::WORD_BCNT_LO) plan_bcnt = wd;
         if (wi >= sgdma_pkg::WORD_DESC_BASE && wi < NUM_WORDS
             && wi[1:0] == sgdma_pkg::DESC_CNT_LO)
            plan_counts[int'((wi - sgdma_pkg::WORD_DESC_BASE) >> 2)] = wd;
      end
   endtask

   task automatic queue_noise();
      logic [1:0]  c;
      logic [6:0]  w;
      logic [31:0] d;
      c = 2'($urandom_range(0, 3));
      w = ($urandom_range(0, 3) == 0) ? 7'($urandom_range(NUM_WORDS, 127))
                                       : 7'($urandom_range(0, NUM_WORDS - 1));
      d = pick_word();
      if (w >= sgdma_pkg::WORD_DESC_BASE && w < NUM_WORDS && w[1:0] == sgdma_pkg::DESC_CNT_LO)
         d = pick_count();
      queue_access(c, w, d);
   endtask

   // set up a scatter-gather transfer, start it and tick it, usually to completion
   task automatic queue_transfer();
      int          nd, r, ticks;
      logic [31:0] blocks, tot, c, cmd_word;
      nd = ($urandom_range(0, 9) == 0) ? NUM_DESC : $urandom_range(1, 4);
      r  = $urandom_range(0, 19);
      if (r == 0) blocks = 32'd0;
      else if (r == 1) blocks = 32'h0080_0000;          // byte total wraps to zero
      else if (r == 2) blocks = $urandom | 32'h0001_0000; // walks every descriptor
      else blocks = $urandom_range(1, 4);
      queue_access(sgdma_pkg::REQ_CMD_WRITE, sgdma_pkg::WORD_BADDR_HI,
                   ($urandom_range(0, 3) == 0) ? pick_word() : 32'h0);
      queue_access(sgdma_pkg::REQ_CMD_WRITE, sgdma_pkg::WORD_BADDR_LO, pick_word());
      if ($urandom_range(0, 3) == 0)
         queue_access(sgdma_pkg::REQ_CMD_WRITE, sgdma_pkg::WORD_BCNT_HI, pick_word());
      queue_access(sgdma_pkg::REQ_CMD_WRITE, sgdma_pkg::WORD_BCNT_LO, blocks);
      for (int d = 0; d < nd; d++) begin
         if ($urandom_range(0, 1) == 0)
            queue_access(sgdma_pkg::REQ_CMD_WRITE, desc_word(d, sgdma_pkg::DESC_ADDR_LO),
                         pick_word());
         if ($urandom_range(0, 7) == 0)
            queue_access(sgdma_pkg::REQ_CMD_WRITE, desc_word(d, sgdma_pkg::DESC_ADDR_HI),
                         pick_word());
         queue_access(sgdma_pkg::REQ_CMD_WRITE, desc_word(d, sgdma_pkg::DESC_CNT_LO),
                      pick_count());
         if ($urandom_range(0, 7) == 0)
            queue_access(sgdma_pkg::REQ_CMD_WRITE, desc_word(d, sgdma_pkg::DESC_CNT_HI),
                         pick_word());
      end
      if ($urandom_range(0, 3) == 0)
         queue_access(sgdma_pkg::REQ_CMD_READ, 7'($urandom_range(0, NUM_WORDS - 1)), pick_word());
      if ($urandom_range(0, 1) == 0)
         queue_access(sgdma_pkg::REQ_CMD_WRITE, sgdma_pkg::WORD_COMMAND, 32'h0);
      r = $urandom_range(0, 9);
      if (r < 5) cmd_word = sgdma_pkg::CMD_DISK_TO_MEM;
      else if (r < 8) cmd_word = CMD_MEM_TO_DISK;
      else cmd_word = $urandom | 32'h8000_0000;
      queue_access(sgdma_pkg::REQ_CMD_WRITE, sgdma_pkg::WORD_COMMAND, cmd_word);

      tot   = plan_bcnt << sgdma_pkg::BLOCK_SHIFT;
      ticks = 1;
      if (tot != 0) begin
         ticks = 0;
         for (int d = 0; d < NUM_DESC && tot != 0; d++) begin
            c     = plan_counts[d];
            ticks += (c == 0) ? 1 : int'((c + 32'd511) / 32'(CHUNK));
            tot   = (tot > c) ? tot - c : '0;
         end
      end
      // sometimes stop short so the next start lands on a busy controller
      if ($urandom_range(0, 9) == 0) ticks = ticks - 1;
      else ticks = ticks + $urandom_range(0, 2);
      for (int t = 0; t < ticks; t++) begin
         r = $urandom_range(0, 15);
         if (r == 0)
            queue_access(sgdma_pkg::REQ_CMD_READ, 7'($urandom_range(0, NUM_WORDS - 1)),
                         pick_word());
         else if (r == 1)
            queue_access(sgdma_pkg::REQ_CMD_WRITE, sgdma_pkg::WORD_COMMAND,
                         $urandom_range(0, 2));
         queue_access(sgdma_pkg::REQ_CMD_TICK, 7'($urandom_range(0, 127)), pick_word());
      end
      queue_access(sgdma_pkg::REQ_CMD_READ, sgdma_pkg::WORD_STATUS, pick_word());
      if ($urandom_range(0, 4) != 0)
         queue_access(sgdma_pkg::REQ_CMD_WRITE, sgdma_pkg::WORD_STATUS, 32'h0);
      else
         queue_access(sgdma_pkg::REQ_CMD_WRITE, sgdma_pkg::WORD_STATUS, pick_word());
   endtask

   task automatic queue_random_phase(input int n);
      int start;
      start = queued_total;
      queue_access(sgdma_pkg::REQ_CMD_READ, sgdma_pkg::WORD_CAP_HI, pick_word());
      queue_access(sgdma_pkg::REQ_CMD_READ, sgdma_pkg::WORD_CAP_LO, pick_word());
      while (queued_total - start < n) begin
         if ($urandom_range(0, 9) < 7) queue_transfer();
         else repeat ($urandom_range(1, 5)) queue_noise();
      end
   endtask

   task automatic write_capacity(input logic [63:0] v);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= v;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      capacity = v;
   endtask

   task automatic wait_idle();
      do @(negedge clock);
      while (access_q.size() != 0 || req_valid || awaited_replies.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_left = 0;
      end else begin
         if (req_valid && !req_stall) begin
            apply_access(req_cmd, req_word_index, req_write_data, predicted);
            awaited_replies.push_back(predicted);
            gap_left = idle_on ? pick_gap() : 0;
         end
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (access_q.size() > 0) begin
               next_access = access_q.pop_front();
               req_valid      <= 1'b1;
               req_cmd        <= next_access.cmd;
               req_word_index <= next_access.word_index;
               req_write_data <= next_access.write_data;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // response monitor and back-pressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            observed = {rsp_read_data, rsp_chunk_valid, rsp_chunk_to_memory, rsp_chunk_disk_offset,
                        rsp_chunk_mem_addr, rsp_chunk_length, rsp_busy_res, rsp_irq, rsp_done_res};
            replies_seen++;
            if (awaited_replies.size() == 0) begin
               fault_count++;
               if (reported < 10) begin
                  reported++;
                  $display("unexpected response transaction: %s", reply_str(observed));
               end
            end else begin
               expected_reply = awaited_replies.pop_front();
               if (observed !== expected_reply) begin
                  fault_count++;
                  if (reported < 10) begin
                     reported++;
                     $display("mismatch on response %0d", replies_seen);
                     $display("  expected %s", reply_str(expected_reply));
                     $display("  actual   %s", reply_str(observed));
                  end
               end
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
            // one long hold-off while requests keep coming, so the input backs up
            if (!long_hold_done && replies_seen >= LONG_HOLD_AT) begin
               long_hold_done = 1'b1;
               stall_left = 250;
            end else if (idle_on && $urandom_range(0, 499) == 0) begin
               stall_left = $urandom_range(80, 200);
            end else if (idle_on && $urandom_range(0, 3) == 0) begin
               stall_left = pick_gap();
            end
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", QUIET_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      write_capacity(64'hffff_ffff_ffff_ffff);

      // directed: window edges, capacity words, idle ticks, empty and walked transfers
      idle_on = 1'b0;
      queue_access(sgdma_pkg::REQ_CMD_READ, sgdma_pkg::WORD_CAP_HI, 32'h0);
      queue_access(sgdma_pkg::REQ_CMD_READ, sgdma_pkg::WORD_CAP_LO, 32'h0);
      queue_access(sgdma_pkg::REQ_CMD_WRITE, sgdma_pkg::WORD_CAP_LO, 32'h0);
      queue_access(sgdma_pkg::REQ_CMD_WRITE, 7'(NUM_WORDS), 32'hffff_ffff);
      queue_access(sgdma_pkg::REQ_CMD_READ, 7'd127, 32'hffff_ffff);
      queue_access(sgdma_pkg::REQ_CMD_TICK, sgdma_pkg::WORD_STATUS, 32'h0);
      queue_access(REQ_CMD_UNUSED, sgdma_pkg::WORD_COMMAND, sgdma_pkg::CMD_DISK_TO_MEM);
      queue_access(sgdma_pkg::REQ_CMD_WRITE, sgdma_pkg::WORD_BCNT_LO, 32'h0);
      queue_access(sgdma_pkg::REQ_CMD_WRITE, sgdma_pkg::WORD_COMMAND, sgdma_pkg::CMD_DISK_TO_MEM);
      queue_access(sgdma_pkg::REQ_CMD_TICK, sgdma_pkg::WORD_STATUS, 32'h0);
      queue_access(sgdma_pkg::REQ_CMD_READ, sgdma_pkg::WORD_STATUS, 32'h0);
      queue_access(sgdma_pkg::REQ_CMD_WRITE, sgdma_pkg::WORD_STATUS, 32'h0);
      queue_access(sgdma_pkg::REQ_CMD_WRITE, sgdma_pkg::WORD_BADDR_HI, 32'hffff_ffff);
      queue_access(sgdma_pkg::REQ_CMD_WRITE, sgdma_pkg::WORD_BADDR_LO, 32'hffff_ffff);
      queue_access(sgdma_pkg::REQ_CMD_WRITE, sgdma_pkg::WORD_BCNT_LO, 32'd3);
      queue_access(sgdma_pkg::REQ_CMD_WRITE, desc_word(1, sgdma_pkg::DESC_ADDR_LO), 32'hffff_fe00);
      queue_access(sgdma_pkg::REQ_CMD_WRITE, desc_word(1, sgdma_pkg::DESC_CNT_LO), 32'd700);
      queue_access(sgdma_pkg::REQ_CMD_WRITE, desc_word(2, sgdma_pkg::DESC_CNT_LO), 32'd1000);
      queue_access(sgdma_pkg::REQ_CMD_WRITE, sgdma_pkg::WORD_COMMAND, CMD_MEM_TO_DISK);
      repeat (4) queue_access(sgdma_pkg::REQ_CMD_TICK, sgdma_pkg::WORD_STATUS, 32'h0);
      // restart attempt while busy; direction follows the live command word
      queue_access(sgdma_pkg::REQ_CMD_WRITE, sgdma_pkg::WORD_COMMAND, 32'h0);
      queue_access(sgdma_pkg::REQ_CMD_WRITE, sgdma_pkg::WORD_COMMAND, sgdma_pkg::CMD_DISK_TO_MEM);
      queue_access(sgdma_pkg::REQ_CMD_TICK, sgdma_pkg::WORD_STATUS, 32'h0);
      wait_idle();

      write_capacity(64'h0);
      idle_on = 1'b1;
      queue_random_phase(200);
      wait_idle();

      write_capacity({$urandom, $urandom});
      idle_on = 1'b0;
      queue_random_phase(200);
      wait_idle();

      write_capacity(64'h0000_0001_0000_0000);
      idle_on = 1'b1;
      queue_random_phase(220);
      wait_idle();

      repeat (8) @(negedge clock);
      fault_count += awaited_replies.size();
      if (fault_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
